>>> hw/rtl/swlp_pkg.sv
// ----------------------------------------------------------------------------
// swlp_pkg
// Types and constants shared by the stopwatch with long-press control.
// ----------------------------------------------------------------------------
package swlp_pkg;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_PRESS   = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_CMD     = 2'd3
    } t_req_kind;

    localparam logic [7:0] CMD_IDENT = 8'h49;
    localparam logic [7:0] CMD_RESET = 8'h52;
    localparam logic [7:0] CMD_START = 8'h53;
    localparam logic [7:0] CMD_STOP  = 8'h5A;

    localparam int          PADDR_W          = 3;
    localparam int          PDATA_W          = 32;
    localparam logic        REG_LONG_PRESS   = 1'b0;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1500;

    typedef struct packed {
        logic clear;
        logic inc;
    } t_swlp_ctl;

    typedef struct packed {
        logic [2:0] minutes_tens;
        logic [3:0] minutes_ones;
        logic [2:0] seconds_tens;
        logic [3:0] seconds_ones;
        logic [3:0] millis_hundreds;
        logic [3:0] millis_tens;
        logic [3:0] millis_ones;
    } t_swlp_time;

endpackage

>>> hw/rtl/swlp_req_if.sv
// ----------------------------------------------------------------------------
// swlp_req_if
// Request channel: tick, button edges and command bytes.
// ----------------------------------------------------------------------------
interface swlp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] cmd_byte;

    modport source (output valid, output req_type, output cmd_byte, input ready);
    modport sink   (input valid, input req_type, input cmd_byte, output ready);
endinterface

>>> hw/rtl/swlp_res_if.sv
// ----------------------------------------------------------------------------
// swlp_res_if
// Result channel: elapsed time digits and status flags.
// ----------------------------------------------------------------------------
interface swlp_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] minutes_tens;
    logic [3:0] minutes_ones;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_ones;
    logic [3:0] millis_hundreds;
    logic [3:0] millis_tens;
    logic [3:0] millis_ones;
    logic       is_running;
    logic       ident_reply;

    modport source (
        output valid, output minutes_tens, output minutes_ones, output seconds_tens,
        output seconds_ones, output millis_hundreds, output millis_tens,
        output millis_ones, output is_running, output ident_reply, input ready
    );
    modport sink (
        input valid, input minutes_tens, input minutes_ones, input seconds_tens,
        input seconds_ones, input millis_hundreds, input millis_tens,
        input millis_ones, input is_running, input ident_reply, output ready
    );
endinterface

>>> hw/rtl/swlp_digits.sv
// ----------------------------------------------------------------------------
// swlp_digits
// Elapsed time held as MM:SS.mmm decimal digits with a binary shadow count
// that returns all digits to zero when the 32-bit millisecond count wraps.
// ----------------------------------------------------------------------------
module swlp_digits
    import swlp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_swlp_ctl  i_ctl,
    output t_swlp_time o_time_next
);

    logic [31:0] r_bin;
    logic [31:0] n_bin;
    t_swlp_time  r_time;
    t_swlp_time  n_time;

    always_comb begin
        n_bin  = r_bin;
        n_time = r_time;
        if (i_ctl.clear) begin
            n_bin  = '0;
            n_time = '0;
        end else if (i_ctl.inc) begin
            n_bin = r_bin + 32'd1;
            if (r_bin == '1) begin
                n_time = '0;
            end else if (r_time.millis_ones != 4'd9) begin
                n_time.millis_ones = r_time.millis_ones + 4'd1;
            end else begin
                n_time.millis_ones = '0;
                if (r_time.millis_tens != 4'd9) begin
                    n_time.millis_tens = r_time.millis_tens + 4'd1;
                end else begin
                    n_time.millis_tens = '0;
                    if (r_time.millis_hundreds != 4'd9) begin
                        n_time.millis_hundreds = r_time.millis_hundreds + 4'd1;
                    end else begin
                        n_time.millis_hundreds = '0;
                        if (r_time.seconds_ones != 4'd9) begin
                            n_time.seconds_ones = r_time.seconds_ones + 4'd1;
                        end else begin
                            n_time.seconds_ones = '0;
                            if (r_time.seconds_tens != 3'd5) begin
                                n_time.seconds_tens = r_time.seconds_tens + 3'd1;
                            end else begin
                                n_time.seconds_tens = '0;
                                if (r_time.minutes_ones != 4'd9) begin
                                    n_time.minutes_ones = r_time.minutes_ones + 4'd1;
                                end else begin
                                    n_time.minutes_ones = '0;
                                    if (r_time.minutes_tens != 3'd5) begin
                                        n_time.minutes_tens = r_time.minutes_tens + 3'd1;
                                    end else begin
                                        n_time.minutes_tens = '0;
                                    end
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin  <= '0;
            r_time <= '0;
        end else begin
            r_bin  <= n_bin;
            r_time <= n_time;
        end
    end

    assign o_time_next = n_time;

endmodule

>>> hw/rtl/stopwatch_long_press_control.sv
// ----------------------------------------------------------------------------
// stopwatch_long_press_control
// Stopwatch with short-press start/stop, long-press clear and command bytes.
// Result: an accepted request's time and flags are held in the result register.
// Throughput: one request per cycle while results are taken; request ready
// follows result ready through the single result register.
// Reset: synchronous active-low; time digits, state flags and counters clear
// to zero (result register excepted), long-press limit returns to 1500 ms.
// ----------------------------------------------------------------------------
module stopwatch_long_press_control
    import swlp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    swlp_req_if.sink           i_req,
    swlp_res_if.source         o_res,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output logic [PDATA_W-1:0] o_prdata,
    output logic               o_pready
);

    logic [15:0] r_long_press;
    logic [31:0] r_now;
    logic [31:0] n_now;
    logic [31:0] r_press_start;
    logic [31:0] n_press_start;
    logic        r_run;
    logic        n_run;
    logic        r_holding;
    logic        n_holding;
    logic        r_long_seen;
    logic        n_long_seen;
    logic        r_out_valid;
    logic        n_out_valid;
    logic        r_is_running;
    logic        r_ident;
    logic        n_ident;
    t_swlp_time  r_out_time;
    t_swlp_time  time_next;
    t_swlp_ctl   ctl;
    logic        accept;
    logic        reg_sel;
    logic        start;
    logic        clear_req;
    logic [31:0] hold_now;
    logic [31:0] hold_next;

    // configuration port
    assign o_pready = 1'b1;
    assign reg_sel  = (i_paddr[2] == REG_LONG_PRESS);
    assign o_prdata = reg_sel ? {16'd0, r_long_press} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= LONG_PRESS_RESET;
        end else if (i_psel && i_penable && i_pwrite && reg_sel) begin
            r_long_press <= i_pwdata[15:0];
        end
    end

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign hold_now  = r_now - r_press_start;
    assign hold_next = n_now - n_press_start;

    always_comb begin
        n_now         = r_now;
        n_press_start = r_press_start;
        n_run         = r_run;
        n_holding     = r_holding;
        n_long_seen   = r_long_seen;
        n_ident       = 1'b0;
        start         = 1'b0;
        clear_req     = 1'b0;
        case (i_req.req_type)
            REQ_TICK: begin
                n_now = r_now + 32'd1;
            end
            REQ_PRESS: begin
                n_press_start = r_now;
                n_holding     = 1'b1;
                n_long_seen   = 1'b0;
            end
            REQ_RELEASE: begin
                n_holding = 1'b0;
                if (hold_now < {16'd0, r_long_press}) begin
                    if (r_run) begin
                        n_run = 1'b0;
                    end else begin
                        n_run = 1'b1;
                        start = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        // long press requests a clear once per press; it takes effect only while stopped
        if (n_holding && !n_long_seen && (hold_next > {16'd0, r_long_press})) begin
            clear_req   = 1'b1;
            n_long_seen = 1'b1;
        end
        if (i_req.req_type == REQ_CMD) begin
            case (i_req.cmd_byte)
                CMD_IDENT: n_ident   = 1'b1;
                CMD_RESET: clear_req = 1'b1;
                CMD_START: begin
                    n_run = 1'b1;
                    start = 1'b1;
                end
                CMD_STOP:  n_run = 1'b0;
                default: ;
            endcase
        end
        ctl.clear = accept && (start || (clear_req && !n_run));
        ctl.inc   = accept && n_run && !start && (i_req.req_type == REQ_TICK);
    end

    swlp_digits u_digits (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_time_next (time_next)
    );

    assign n_out_valid = accept || (r_out_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now         <= '0;
            r_press_start <= '0;
            r_run         <= 1'b0;
            r_holding     <= 1'b0;
            r_long_seen   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_now         <= n_now;
                r_press_start <= n_press_start;
                r_run         <= n_run;
                r_holding     <= n_holding;
                r_long_seen   <= n_long_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_time   <= time_next;
            r_is_running <= n_run;
            r_ident      <= n_ident;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.minutes_tens    = r_out_time.minutes_tens;
    assign o_res.minutes_ones    = r_out_time.minutes_ones;
    assign o_res.seconds_tens    = r_out_time.seconds_tens;
    assign o_res.seconds_ones    = r_out_time.seconds_ones;
    assign o_res.millis_hundreds = r_out_time.millis_hundreds;
    assign o_res.millis_tens     = r_out_time.millis_tens;
    assign o_res.millis_ones     = r_out_time.millis_ones;
    assign o_res.is_running      = r_is_running;
    assign o_res.ident_reply     = r_ident;

    a_accept_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_res.valid
    ) else $error("accepted request produced no result");

    a_running_matches: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.is_running == r_run)
    ) else $error("result running flag differs from state");

    a_ident_only_on_cmd: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (accept && !((i_req.req_type == REQ_CMD) && (i_req.cmd_byte == CMD_IDENT)))
            |=> !o_res.ident_reply
    ) else $error("identify reply without identify command");

    a_digit_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.seconds_tens <= 3'd5) && (o_res.minutes_tens <= 3'd5)
                         && (o_res.millis_ones <= 4'd9) && (o_res.seconds_ones <= 4'd9))
    ) else $error("time digit out of range");

endmodule
